// ----- rtl/dbdl_pkg.sv -----
`default_nettype none

package dbdl_pkg;

	localparam int unsigned MAX_DELAY_DEF   = 1024;
	localparam int unsigned SAMPLE_BITS_DEF = 24;
	localparam int unsigned LEN_BITS        = 11;
	localparam int unsigned LOSS_BITS       = 16;
	localparam int unsigned UNITY           = 32768;
	localparam int unsigned FRAC_BITS       = 15;
	localparam int unsigned APB_DATA_BITS   = 32;
	localparam int unsigned APB_ADDR_BITS   = 3;

	typedef enum logic [0:0] {
		REG_DELAY_LENGTH = 1'b0,
		REG_LOSS_FACTOR  = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/dbdl_mem.sv -----
`default_nettype none

module dbdl_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dbdl_mix.sv -----
`default_nettype none

module dbdl_mix
	import dbdl_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic signed [SAMPLE_BITS-1:0] held,
	input  wire logic signed [SAMPLE_BITS-1:0] delayed,
	input  wire logic        [LOSS_BITS-1:0]   loss,
	output logic signed      [SAMPLE_BITS-1:0] result
);

	localparam int unsigned DW = SAMPLE_BITS + 1;
	localparam int unsigned PW = LOSS_BITS + 1 + DW;

	// The mix is rewritten as delayed + loss * (held - delayed) / 1.0, which is exact
	// because the unity term contributes no fraction bits.
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rounded;
	logic signed [PW-1:0] shifted;

	always_comb begin
		diff    = DW'(held) - DW'(delayed);
		prod    = PW'(signed'({1'b0, loss})) * PW'(diff);
		rounded = prod + PW'(signed'({1'b0, 1'b1, {(FRAC_BITS-1){1'b0}}}));
		shifted = rounded >>> FRAC_BITS;
		result  = delayed + shifted[SAMPLE_BITS-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/damped_bidirectional_delay_line_core.sv -----
`default_nettype none

// Two-way damped waveguide section. Each request on the slave stream carries one sample
// entering at end A and one at end B; each goes into its own circular delay line of
// delay_length samples, and the sample leaving the opposite line passes a one-pole
// lowpass weighted by loss_factor (unsigned Q1.15, 32768 is pure hold) before it
// leaves on the master stream. The block takes one request per clock cycle unless the
// master stream stalls, and presents each result when the filter stage advances: the
// accepting edge issues the synchronous line read at the known read position, and the
// advancing edge runs the filter and write-back, whose feedback through the held
// output sets the clock period. Both lines read as zero after reset without a clearing
// pass, because a fill count marks the entries written so far. The user must write
// configuration only while no request is in flight; the block does not enforce it.
module damped_bidirectional_delay_line_core
	import dbdl_pkg::*;
#(
	parameter int unsigned MAX_DELAY   = MAX_DELAY_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	// sample_in_a, sample_in_b, zero padding
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	// sample_out_a, sample_out_b, zero padding
	output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
	input  wire logic                                     psel,
	input  wire logic                                     penable,
	input  wire logic                                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0]                 paddr,
	input  wire logic [APB_DATA_BITS-1:0]                 pwdata,
	output logic      [APB_DATA_BITS-1:0]                 prdata,
	output logic                                          pready
);

	localparam int unsigned SB     = SAMPLE_BITS;
	localparam int unsigned TW     = ((2*SB+7)/8)*8;
	localparam int unsigned ADDR_W = $clog2(MAX_DELAY);
	localparam int unsigned FILL_W = ADDR_W + 1;
	localparam int unsigned CW     = (FILL_W > LEN_BITS) ? FILL_W : LEN_BITS;

	logic [LEN_BITS-1:0]  len_q;
	logic [LOSS_BITS-1:0] loss_q;
	logic [ADDR_W-1:0]    pos_q;
	logic [FILL_W-1:0]    fill_q;

	logic                 s1_valid_q;
	logic signed [SB-1:0] a_s1, b_s1;
	logic [ADDR_W-1:0]    pos_s1;
	logic                 byp_s1, zero_s1;
	logic signed [SB-1:0] byp_a_s1, byp_b_s1;

	logic signed [SB-1:0] held_a_q, held_b_q;
	logic                 m_valid_q;

	logic                 accept, s1_adv, cfg_wr;
	cfg_reg_t             cfg_sel;
	logic [LEN_BITS-1:0]  len_wr;
	logic [LOSS_BITS-1:0] loss_wr;
	logic [CW-1:0]        pos_inc;
	logic [ADDR_W-1:0]    pos_next;

	logic [SB-1:0]        rd_a2b, rd_b2a;
	logic signed [SB-1:0] del_a2b, del_b2a;
	logic signed [SB-1:0] mix_a, mix_b;

	assign s1_adv   = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = TW'({held_b_q, held_a_q});
	assign pready   = 1'b1;

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_comb begin
		len_wr = pwdata[LEN_BITS-1:0];
		if (len_wr == '0) begin
			len_wr = LEN_BITS'(1);
		end else if (32'(len_wr) > 32'(MAX_DELAY)) begin
			len_wr = LEN_BITS'(MAX_DELAY);
		end
		loss_wr = pwdata[LOSS_BITS-1:0];
		if (32'(loss_wr) > 32'(UNITY)) begin
			loss_wr = LOSS_BITS'(UNITY);
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_DELAY_LENGTH: prdata = APB_DATA_BITS'(len_q);
			REG_LOSS_FACTOR:  prdata = APB_DATA_BITS'(loss_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		pos_inc = CW'(pos_q) + CW'(1);
		if (pos_inc >= CW'(len_q)) begin
			pos_next = '0;
		end else begin
			pos_next = pos_inc[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_BITS'(1);
			loss_q <= '0;
			pos_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_DELAY_LENGTH: begin
					len_q <= len_wr;
					if (CW'(pos_q) >= CW'(len_wr)) begin
						pos_q <= '0;
					end
				end
				REG_LOSS_FACTOR: begin
					loss_q <= loss_wr;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			fill_q     <= '0;
			held_a_q   <= '0;
			held_b_q   <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= 1'b1;
				held_a_q  <= mix_a;
				held_b_q  <= mix_b;
				if (FILL_W'(pos_s1) == fill_q) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1     <= s_tdata[SB-1:0];
			b_s1     <= s_tdata[2*SB-1:SB];
			pos_s1   <= pos_q;
			byp_s1   <= s1_adv && (pos_s1 == pos_q);
			byp_a_s1 <= a_s1;
			byp_b_s1 <= b_s1;
			zero_s1  <= FILL_W'(pos_q) >= fill_q;
		end
	end

	dbdl_mem #(
		.DEPTH (MAX_DELAY),
		.WIDTH (SB)
	) u_line_a2b (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pos_q),
		.rd_data (rd_a2b),
		.wr_en   (s1_adv),
		.wr_addr (pos_s1),
		.wr_data (a_s1)
	);

	dbdl_mem #(
		.DEPTH (MAX_DELAY),
		.WIDTH (SB)
	) u_line_b2a (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pos_q),
		.rd_data (rd_b2a),
		.wr_en   (s1_adv),
		.wr_addr (pos_s1),
		.wr_data (b_s1)
	);

	always_comb begin
		priority if (byp_s1) begin
			del_a2b = byp_a_s1;
			del_b2a = byp_b_s1;
		end else if (zero_s1) begin
			del_a2b = '0;
			del_b2a = '0;
		end else begin
			del_a2b = rd_a2b;
			del_b2a = rd_b2a;
		end
	end

	dbdl_mix #(
		.SAMPLE_BITS (SB)
	) u_mix_a (
		.held    (held_a_q),
		.delayed (del_b2a),
		.loss    (loss_q),
		.result  (mix_a)
	);

	dbdl_mix #(
		.SAMPLE_BITS (SB)
	) u_mix_b (
		.held    (held_b_q),
		.delayed (del_a2b),
		.loss    (loss_q),
		.result  (mix_b)
	);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) < CW'(len_q))
		else $error("read position outside delay length");

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		len_q != '0 && 32'(len_q) <= 32'(MAX_DELAY))
		else $error("delay length outside legal range");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(MAX_DELAY))
		else $error("fill count beyond line depth");

	a_loss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(loss_q) <= 32'(UNITY))
		else $error("loss factor above unity");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(pos_s1))
		else $error("stalled request lost from the filter stage");

endmodule

`default_nettype wire
